FILE: rtl/assert_macros.svh
// Assertion macros for the RTL files (included by the trainer top level)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lrgd_pkg.sv
// Types and constants of the linear regression trainer
`timescale 1ns / 1ps
package lrgd_pkg;

  localparam int ACC_W = 64;
  localparam int ERR_W = 52;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [ERR_W-1:0] ERR_MAX = {ERR_W{1'b1}};
  localparam logic [34:0] DELTA_CAP = 35'h4_0000_0000;

  localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ITERATION_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATIENCE_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_WEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_BIAS = 3'd4;

  typedef struct packed {
    logic signed [15:0] sample_input;
    logic signed [15:0] sample_target;
    logic               last_sample;
  } sample_beat_t;

  typedef struct packed {
    logic signed [31:0] trained_weight;
    logic signed [31:0] trained_bias;
    logic [ERR_W-1:0]   lowest_error;
  } result_beat_t;

  typedef struct packed {
    logic signed [15:0] feature;
    logic signed [15:0] target;
  } sample_pair_t;

  typedef enum logic {
    PASS_GRAD,
    PASS_ERR
  } pass_mode_e;

  typedef struct packed {
    logic       start;
    pass_mode_e mode;
  } pass_ctrl_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_GRAD_GO,
    ST_GRAD_WAIT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_APPLY,
    ST_ERR_GO,
    ST_ERR_WAIT,
    ST_EDIV_GO,
    ST_EDIV_WAIT,
    ST_DECIDE,
    ST_EMIT
  } trn_state_e;

endpackage

FILE: rtl/lrgd_sample_mem.sv
// Sample store: one write port, one registered read port
`timescale 1ns / 1ps
module lrgd_sample_mem import lrgd_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW = 10
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  sample_pair_t  wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output sample_pair_t  rdata_o
);

  sample_pair_t mem_q [DEPTH];
  sample_pair_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/lrgd_serial_div.sv
// Restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module lrgd_serial_div import lrgd_pkg::*; #(
  parameter int DW = 64,
  parameter int VW = 11
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          busy_o,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);

  localparam int NW = (DW > 1) ? $clog2(DW) : 1;
  localparam logic [NW-1:0] LAST_STEP = NW'(DW - 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] dvd_q;
  logic [VW-1:0] rem_q;
  logic [VW-1:0] dsr_q;
  logic [VW:0]   trial;
  logic          ge;
  logic [VW:0]   diff;

  assign trial = {rem_q, dvd_q[DW-1]};
  assign ge    = trial >= {1'b0, dsr_q};
  assign diff  = trial - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + NW'(1);
      if (cnt_q == LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // shift the quotient into the dividend register as its bits are used up
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DW-2:0], ge};
      rem_q <= ge ? diff[VW-1:0] : trial[VW-1:0];
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

FILE: rtl/lrgd_pass_unit.sv
// Streaming pass over the sample store: gradient sums or squared-error sum
`timescale 1ns / 1ps
module lrgd_pass_unit import lrgd_pkg::*; #(
  parameter int AW = 10,
  parameter int CW = 11
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  pass_ctrl_t              ctrl_i,
  input  logic [CW-1:0]           n_i,
  input  logic signed [31:0]      weight_i,
  input  logic signed [31:0]      bias_i,
  output logic                    rd_en_o,
  output logic [AW-1:0]           rd_addr_o,
  input  sample_pair_t            rd_data_i,
  output logic                    busy_o,
  output logic                    done_o,
  output logic signed [ACC_W-1:0] grad_w_o,
  output logic signed [ACC_W-1:0] grad_b_o,
  output logic [ERR_W-1:0]        err_sum_o
);

  logic          active_q, active_d;
  logic [CW-1:0] idx_q, idx_d;
  pass_mode_e    mode_q;
  logic          last_issue;
  logic          v1_q, v2_q, v3_q, v4_q;
  logic          l1_q, l2_q, l3_q, l4_q;
  logic          done_q;

  logic signed [15:0]      x2_q, y2_q, x3_q;
  logic signed [48:0]      r3_q, r4_q;
  logic signed [ACC_W-1:0] rx4_q;
  logic [ERR_W-1:0]        t4_q;

  logic signed [ACC_W-1:0] gw_q, gb_q;
  logic [ERR_W-1:0]        es_q;

  logic signed [47:0]      wx;
  logic signed [48:0]      r_d;
  logic signed [ACC_W-1:0] rx_d;
  logic [48:0]             mag;
  logic [67:0]             sq;
  logic [ERR_W-1:0]        t_d;
  logic signed [ACC_W-1:0] r_ext;
  logic signed [ACC_W:0]   sum_w, sum_b;
  logic [ERR_W:0]          sum_e;

  assign last_issue = idx_q == CW'(n_i - CW'(1));

  always_comb begin
    active_d = active_q;
    idx_d    = idx_q;
    if (ctrl_i.start) begin
      active_d = 1'b1;
      idx_d    = '0;
    end else if (active_q) begin
      idx_d = idx_q + CW'(1);
      if (last_issue) begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      idx_q    <= '0;
      mode_q   <= PASS_GRAD;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      v4_q     <= 1'b0;
      l1_q     <= 1'b0;
      l2_q     <= 1'b0;
      l3_q     <= 1'b0;
      l4_q     <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      active_q <= active_d;
      idx_q    <= idx_d;
      if (ctrl_i.start) begin
        mode_q <= ctrl_i.mode;
      end
      v1_q   <= active_q;
      l1_q   <= active_q & last_issue;
      v2_q   <= v1_q;
      l2_q   <= l1_q;
      v3_q   <= v2_q;
      l3_q   <= l2_q;
      v4_q   <= v3_q;
      l4_q   <= l3_q;
      done_q <= v4_q & l4_q;
    end
  end

  // residual r = y*2^16 - (w*x + b), then r*x or floor(r^2 / 2^16)
  assign wx    = 48'(weight_i) * 48'(x2_q);
  assign r_d   = 49'($signed({y2_q, 16'h0000})) - 49'(wx) - 49'(bias_i);
  assign rx_d  = ACC_W'(r3_q) * ACC_W'(x3_q);
  assign mag   = r3_q[48] ? 49'(-r3_q) : 49'(r3_q);
  assign sq    = 68'(mag[33:0]) * 68'(mag[33:0]);
  assign t_d   = (|mag[48:34]) ? ERR_MAX : sq[67:16];

  assign r_ext = ACC_W'(r4_q);
  assign sum_w = {gw_q[ACC_W-1], gw_q} + {rx4_q[ACC_W-1], rx4_q};
  assign sum_b = {gb_q[ACC_W-1], gb_q} + {r_ext[ACC_W-1], r_ext};
  assign sum_e = {1'b0, es_q} + {1'b0, t4_q};

  always_ff @(posedge clk_i) begin
    x2_q   <= rd_data_i.feature;
    y2_q   <= rd_data_i.target;
    x3_q   <= x2_q;
    r3_q   <= r_d;
    r4_q   <= r3_q;
    rx4_q  <= rx_d;
    t4_q   <= t_d;
  end

  // saturating accumulation
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      gw_q <= '0;
      gb_q <= '0;
      es_q <= '0;
    end else if (v4_q) begin
      if (mode_q == PASS_GRAD) begin
        if (sum_w[ACC_W] != sum_w[ACC_W-1]) begin
          gw_q <= {sum_w[ACC_W], {(ACC_W-1){~sum_w[ACC_W]}}};
        end else begin
          gw_q <= sum_w[ACC_W-1:0];
        end
        if (sum_b[ACC_W] != sum_b[ACC_W-1]) begin
          gb_q <= {sum_b[ACC_W], {(ACC_W-1){~sum_b[ACC_W]}}};
        end else begin
          gb_q <= sum_b[ACC_W-1:0];
        end
      end else begin
        es_q <= sum_e[ERR_W] ? ERR_MAX : sum_e[ERR_W-1:0];
      end
    end
  end

  assign rd_en_o   = active_q;
  assign rd_addr_o = idx_q[AW-1:0];
  assign busy_o    = active_q | v1_q | v2_q | v3_q | v4_q;
  assign done_o    = done_q;
  assign grad_w_o  = gw_q;
  assign grad_b_o  = gb_q;
  assign err_sum_o = es_q;

endmodule

FILE: rtl/linear_regression_gd_trainer.sv
// Top level of the batch gradient descent linear regression trainer
`timescale 1ns / 1ps
// Samples arrive one beat per cycle while in_ready_o is high, which is only in
// the load state, and are written straight into a sample memory (feature and
// target side by side) until a beat flagged last_sample; beats beyond
// MAX_SAMPLES are dropped but their last flag still counts. Training then
// runs with the input held off: each iteration streams the n stored samples
// through the pass unit for the gradient sums, divides each sum by n on a
// shared 64-step serial divider, scales it by the learning rate with two
// 32x32 products (low and high half of the quotient) in states ST_MUL_LO and
// ST_MUL_HI, streams the samples again for the error sum and divides that by
// n. Training runs at most iteration_limit iterations (one when it is zero),
// fewer when patience runs out. The result beat waits in an output register,
// so loading the next batch may overlap it.
// The configuration registers are to be written only while no batch is in
// training.
module linear_regression_gd_trainer import lrgd_pkg::*; #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  sample_beat_t          in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output result_beat_t          out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

`include "assert_macros.svh"

  localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SAMPLES);

  // configuration registers
  logic [31:0]        lr_q;
  logic [15:0]        iter_lim_q;
  logic [7:0]         pat_lim_q;
  logic signed [31:0] init_w_q;
  logic signed [31:0] init_b_q;

  trn_state_e state_q, state_d;

  logic [CW-1:0]      count_q;
  logic signed [31:0] cur_w_q, cur_b_q;
  logic signed [31:0] best_w_q, best_b_q;
  logic [ERR_W-1:0]   best_err_q;
  logic [ERR_W-1:0]   err_q;
  logic [7:0]         worse_q;
  logic [15:0]        iter_q;
  logic               sel_q;
  logic               neg_q;
  logic [ACC_W-1:0]   mag_q;
  logic [63:0]        lo_q, hi_q;
  logic               out_valid_q;
  result_beat_t       out_data_q;

  logic         in_acc;
  logic         mem_we;
  sample_pair_t mem_wdata;
  logic         rd_en;
  logic [AW-1:0] rd_addr;
  sample_pair_t rd_data;

  pass_ctrl_t              pass_ctrl;
  logic                    pass_busy, pass_done;
  logic signed [ACC_W-1:0] grad_w, grad_b;
  logic [ERR_W-1:0]        err_sum;

  logic             div_start, div_busy, div_done;
  logic [ACC_W-1:0] div_dividend, div_quot;

  logic signed [ACC_W-1:0] grad_sum;
  logic [ACC_W-1:0]        grad_mag;
  logic                    out_load;

  logic             improve;
  logic [7:0]       worse_inc;
  logic             stop_early;
  logic [16:0]      iter_inc, lim_eff;
  logic             iter_done;

  logic [34:0]        res35, delta35;
  logic signed [31:0] cur_sel;
  logic signed [35:0] upd36;
  logic signed [31:0] upd_sat;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q       <= 32'd429497;
      iter_lim_q <= 16'd10000;
      pat_lim_q  <= 8'd3;
      init_w_q   <= '0;
      init_b_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LEARNING_RATE:   lr_q       <= cfg_data_i;
        REG_ITERATION_LIMIT: iter_lim_q <= cfg_data_i[15:0];
        REG_PATIENCE_LIMIT:  pat_lim_q  <= cfg_data_i[7:0];
        REG_INITIAL_WEIGHT:  init_w_q   <= $signed(cfg_data_i);
        REG_INITIAL_BIAS:    init_b_q   <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // sample store
  assign mem_wdata = '{feature: in_data_i.sample_input, target: in_data_i.sample_target};

  lrgd_sample_mem #(
    .DEPTH(MAX_SAMPLES),
    .AW   (AW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(count_q[AW-1:0]),
    .wdata_i(mem_wdata),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  lrgd_pass_unit #(
    .AW(AW),
    .CW(CW)
  ) u_pass (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (pass_ctrl),
    .n_i      (count_q),
    .weight_i (cur_w_q),
    .bias_i   (cur_b_q),
    .rd_en_o  (rd_en),
    .rd_addr_o(rd_addr),
    .rd_data_i(rd_data),
    .busy_o   (pass_busy),
    .done_o   (pass_done),
    .grad_w_o (grad_w),
    .grad_b_o (grad_b),
    .err_sum_o(err_sum)
  );

  // magnitude of the selected gradient sum; the sign is carried aside
  assign grad_sum     = sel_q ? grad_b : grad_w;
  assign grad_mag     = grad_sum[ACC_W-1] ? ACC_W'(-grad_sum) : ACC_W'(grad_sum);
  assign div_dividend = (state_q == ST_EDIV_GO) ? ACC_W'(err_sum) : grad_mag;

  lrgd_serial_div #(
    .DW(ACC_W),
    .VW(CW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (count_q),
    .busy_o    (div_busy),
    .done_o    (div_done),
    .quotient_o(div_quot)
  );

  // iteration bookkeeping
  assign improve    = (iter_q == 16'd0) || (err_q < best_err_q);
  assign worse_inc  = worse_q + 8'd1;
  assign stop_early = !improve && (worse_inc >= pat_lim_q);
  assign iter_inc   = {1'b0, iter_q} + 17'd1;
  assign lim_eff    = (iter_lim_q == 16'd0) ? 17'd1 : {1'b0, iter_lim_q};
  assign iter_done  = iter_inc >= lim_eff;

  // step: floor(mag * lr / 2^31), capped, then added with the sum's sign
  assign res35   = 35'({hi_q[31:0], 1'b0}) + 35'(lo_q[63:31]);
  assign delta35 = ((|hi_q[63:32]) || (res35 > DELTA_CAP)) ? DELTA_CAP : res35;
  assign cur_sel = sel_q ? cur_b_q : cur_w_q;
  assign upd36   = neg_q ? (36'(cur_sel) - $signed({1'b0, delta35}))
                         : (36'(cur_sel) + $signed({1'b0, delta35}));
  always_comb begin
    if (upd36 > 36'sd2147483647) begin
      upd_sat = 32'sh7FFF_FFFF;
    end else if (upd36 < -36'sd2147483648) begin
      upd_sat = 32'sh8000_0000;
    end else begin
      upd_sat = upd36[31:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_valid_i && in_data_i.last_sample) begin
          state_d = ST_GRAD_GO;
        end
      end
      ST_GRAD_GO:   state_d = ST_GRAD_WAIT;
      ST_GRAD_WAIT: begin
        if (pass_done) begin
          state_d = ST_DIV_GO;
        end
      end
      ST_DIV_GO:    state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_d = ST_MUL_LO;
        end
      end
      ST_MUL_LO:    state_d = ST_MUL_HI;
      ST_MUL_HI:    state_d = ST_APPLY;
      ST_APPLY:     state_d = sel_q ? ST_ERR_GO : ST_DIV_GO;
      ST_ERR_GO:    state_d = ST_ERR_WAIT;
      ST_ERR_WAIT: begin
        if (pass_done) begin
          state_d = ST_EDIV_GO;
        end
      end
      ST_EDIV_GO:   state_d = ST_EDIV_WAIT;
      ST_EDIV_WAIT: begin
        if (div_done) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE:    state_d = (stop_early || iter_done) ? ST_EMIT : ST_GRAD_GO;
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_LOAD;
        end
      end
      default:      state_d = ST_LOAD;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready_o      = 1'b0;
    pass_ctrl.start = 1'b0;
    pass_ctrl.mode  = PASS_GRAD;
    div_start       = 1'b0;
    out_load        = 1'b0;
    unique case (state_q)
      ST_LOAD:    in_ready_o = 1'b1;
      ST_GRAD_GO: pass_ctrl.start = 1'b1;
      ST_ERR_GO: begin
        pass_ctrl.start = 1'b1;
        pass_ctrl.mode  = PASS_ERR;
      end
      ST_DIV_GO, ST_EDIV_GO: div_start = 1'b1;
      ST_EMIT:    out_load = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  assign in_acc = in_valid_i && in_ready_o;
  assign mem_we = in_acc && (count_q < MAX_CNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      sel_q       <= 1'b0;
      worse_q     <= '0;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
      cur_w_q     <= '0;
      cur_b_q     <= '0;
      best_w_q    <= '0;
      best_b_q    <= '0;
      best_err_q  <= '0;
    end else begin
      state_q <= state_d;

      // drop beats that find the store full; advance the fill otherwise, and clear it when the result is loaded
      if (mem_we) begin
        count_q <= count_q + CW'(1);
      end else if (out_load) begin
        count_q <= '0;
      end

      if (in_acc && in_data_i.last_sample) begin
        cur_w_q <= init_w_q;
        cur_b_q <= init_b_q;
        worse_q <= '0;
        iter_q  <= '0;
      end

      if (state_q == ST_GRAD_WAIT) begin
        sel_q <= 1'b0;
      end

      if (state_q == ST_APPLY) begin
        if (sel_q) begin
          cur_b_q <= upd_sat;
        end else begin
          cur_w_q <= upd_sat;
        end
        sel_q <= ~sel_q;
      end

      if (state_q == ST_DECIDE) begin
        iter_q <= iter_inc[15:0];
        if (improve) begin
          best_err_q <= err_q;
          best_w_q   <= cur_w_q;
          best_b_q   <= cur_b_q;
          worse_q    <= '0;
        end else begin
          worse_q <= worse_inc;
          if (stop_early) begin
            cur_w_q <= best_w_q;
            cur_b_q <= best_b_q;
          end
        end
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers for the parameter step, the error and the result beat
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DIV_GO) begin
      neg_q <= grad_sum[ACC_W-1];
    end
    if (state_q == ST_DIV_WAIT && div_done) begin
      mag_q <= div_quot;
    end
    if (state_q == ST_MUL_LO) begin
      lo_q <= 64'(mag_q[31:0]) * 64'(lr_q);
    end
    if (state_q == ST_MUL_HI) begin
      hi_q <= 64'(mag_q[63:32]) * 64'(lr_q);
    end
    if (state_q == ST_EDIV_WAIT && div_done) begin
      err_q <= div_quot[ERR_W-1:0];
    end
    if (out_load) begin
      out_data_q.trained_weight <= cur_w_q;
      out_data_q.trained_bias   <= cur_b_q;
      out_data_q.lowest_error   <= best_err_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `ASSERT_ALWAYS(a_count_bound, count_q <= MAX_CNT, "sample count beyond store depth")
  `ASSERT_IMPLIES(a_store_write_idle, mem_we, state_q == ST_LOAD, "store written during training")
  `ASSERT_IMPLIES(a_div_start_free, div_start, !div_busy, "divider started while busy")
  `ASSERT_IMPLIES(a_pass_start_free, pass_ctrl.start, !pass_busy, "pass started while busy")

endmodule
